FILE: rtl/ts_pid_pkg.sv
// Shared constants and types of the transport-stream sync and PID filter.
// No dependencies; imported by the top level.
`default_nettype none

package ts_pid_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PID_W  = 13;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h47;

  // Register index of the wanted PID (byte address 4 * index).
  localparam logic REG_WANTED_PID = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
  } ts_result_t;

endpackage

`default_nettype wire

FILE: rtl/ts_pid_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ts_pid_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 188
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/ts_sync_pid_filter.sv
// Transport-stream packet sync and PID filter, top level.
// Depends on ts_pid_pkg and ts_pid_ram.
//
// Usage:
//   Raw stream bytes enter on the stream channel (stream_valid, stream_stall,
//   stream_byte). A transaction is accepted at a rising edge with stream_valid
//   high and stream_stall low. Bytes of confirmed packets whose PID matches
//   the wanted_pid register leave on the packet channel (packet_valid,
//   packet_stall, packet_byte, is_first, is_last) under the same rules.
//   A packet is confirmed when a 0x47 byte is followed PACKET_BYTES bytes
//   later by another 0x47, so each output byte is produced by the input
//   transaction that arrives PACKET_BYTES bytes after it, and is registered
//   in the output register, or in the skid register if the receiver stalls.
//   Throughput is one byte per clock unless the input stalls. The delay
//   line is a circular buffer in one RAM with one write and one registered
//   read per cycle; the read always prefetches the third-oldest byte, so no
//   interlock cycles are needed. When the receiver stalls, one result waits
//   in the output register and a second in a skid register; only while the
//   skid register is full does the block stall its input.
//   Reset (synchronous, active high) clears the control state, the filter
//   register and the output; the buffer reads as zero until first written,
//   which a fill flag tracks, so no clearing pass is needed.
`default_nettype none

module ts_sync_pid_filter
  import ts_pid_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 188
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Stream input
  input  wire logic              stream_valid,
  output logic                   stream_stall,
  input  wire logic [BYTE_W-1:0] stream_byte,
  // Packet output
  output logic                   packet_valid,
  input  wire logic              packet_stall,
  output logic      [BYTE_W-1:0] packet_byte,
  output logic                   is_first,
  output logic                   is_last,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned PTR_W = $clog2(PACKET_BYTES);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(PACKET_BYTES - 1);
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W+1)'(PACKET_BYTES);

  // Configuration register.
  logic [PID_W-1:0] wanted_pid;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WANTED_PID) ?
                  {{(APB_DW-PID_W){1'b0}}, wanted_pid} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_pid <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_WANTED_PID) begin
      wanted_pid <= pwdata[PID_W-1:0];
    end
  end

  // Delay line: circular buffer. wptr points at the oldest byte, which is
  // also where the incoming byte is written. head0 and head1 hold the two
  // oldest bytes; the RAM read data holds the third oldest.
  logic              accept;
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  wptr_next;
  logic              full;
  logic              full_next;
  logic [PTR_W:0]    rd_sum;
  logic [PTR_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              rd_ok;
  logic [BYTE_W-1:0] head0;
  logic [BYTE_W-1:0] head1;
  logic [BYTE_W-1:0] head2;

  assign accept    = stream_valid && !stream_stall;
  assign wptr_next = !accept ? wptr : ((wptr == LAST_PTR) ? '0 : wptr + 1'b1);
  assign full_next = full || (accept && wptr == LAST_PTR);
  assign rd_sum    = {1'b0, wptr_next} + (PTR_W+1)'(2);
  assign rd_addr   = (rd_sum >= DEPTH_X) ? PTR_W'(rd_sum - DEPTH_X) : rd_sum[PTR_W-1:0];

  // Entries not yet written read as zero.
  assign head2 = rd_ok ? rd_data : '0;

  ts_pid_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PACKET_BYTES)
  ) u_delay_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wptr),
    .wr_data (stream_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      full  <= 1'b0;
      rd_ok <= 1'b0;
      head0 <= '0;
      head1 <= '0;
    end else begin
      wptr  <= wptr_next;
      full  <= full_next;
      rd_ok <= full_next || (rd_addr < wptr_next);
      if (accept) begin
        head0 <= head1;
        head1 <= head2;
      end
    end
  end

  // Packet tracking. A zero count means the block is hunting for sync.
  logic [PTR_W-1:0]  bytes_left;
  logic              passes;
  logic              hunting;
  logic              sync_hit;
  logic              pid_match;
  logic              res_valid;
  ts_result_t        res;

  assign hunting   = (bytes_left == '0);
  assign sync_hit  = hunting && head0 == SYNC_BYTE && stream_byte == SYNC_BYTE;
  assign pid_match = ({head1[4:0], head2} == wanted_pid);
  assign res_valid = accept && ((!hunting && passes) || (sync_hit && pid_match));
  assign res.data  = head0;
  assign res.first = hunting;
  assign res.last  = (bytes_left == PTR_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      passes     <= 1'b0;
    end else if (accept) begin
      if (!hunting) begin
        bytes_left <= bytes_left - 1'b1;
      end else if (sync_hit) begin
        bytes_left <= LAST_PTR;
        passes     <= pid_match;
      end
    end
  end

  // Output register with a skid register behind it.
  ts_result_t out_reg;
  ts_result_t skid;
  logic       skid_valid;
  logic       out_free;

  assign out_free     = !packet_valid || !packet_stall;
  assign stream_stall = skid_valid;
  assign packet_byte  = out_reg.data;
  assign is_first     = out_reg.first;
  assign is_last      = out_reg.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        packet_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        packet_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> packet_valid)
    else $error("skid register holds a transaction while the output is empty");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    packet_valid |-> !(is_first && is_last))
    else $error("output byte flagged both first and last");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (accept && bytes_left != '0) |=> (bytes_left + 1'b1 == $past(bytes_left)))
    else $error("packet byte count did not step down on an accepted byte");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    wptr <= LAST_PTR)
    else $error("delay line pointer out of range");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_ts_sync_pid_filter.sv
// Self-checking testbench of the transport-stream sync and PID filter.
// Holds its own byte-level predictor and drives the stream, packet and APB ports.
// Depends on ts_pid_pkg and ts_sync_pid_filter.
module tb_ts_sync_pid_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import ts_pid_pkg::*;

  localparam int unsigned PKT_LEN       = 188;
  localparam int unsigned RANDOM_BYTES  = 400;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RUN_LIMIT_NS  = 4_000_000;

  // Byte addresses of the configuration space. Index one holds no register.
  localparam int unsigned REG_NONE = 1;
  localparam logic [APB_AW-1:0] ADDR_WANTED_PID  = APB_AW'(REG_WANTED_PID * 4);
  localparam logic [APB_AW-1:0] ADDR_NO_REGISTER = APB_AW'(REG_NONE * 4);

  localparam logic [PID_W-1:0] PID_LOWEST  = '0;
  localparam logic [PID_W-1:0] PID_HIGHEST = '1;

  // Predictor of the filter: a copy of the delay line, the packet counter,
  // the latched pass decision and the wanted PID, plus the queue of packet
  // bytes that the block still owes.
  class passed_packet_predictor;
    logic [BYTE_W-1:0] delay_line [PKT_LEN];
    int unsigned       bytes_left;
    bit                passing;
    logic [PID_W-1:0]  wanted_pid;
    ts_result_t        expected_bytes [$];
    int unsigned       mismatches;

    function new();
      foreach (delay_line[i]) delay_line[i] = '0;
      bytes_left = 0;
      passing    = 1'b0;
      wanted_pid = '0;
      mismatches = 0;
    endfunction

    function void write_register(int unsigned index, logic [APB_DW-1:0] value);
      if (index == REG_WANTED_PID) wanted_pid = value[PID_W-1:0];
    endfunction

    // One accepted stream byte: the byte leaving the delay line is either
    // part of a packet in progress or the candidate start of a new one.
    function void take_stream_byte(logic [BYTE_W-1:0] incoming);
      logic [BYTE_W-1:0] leaving;
      logic [PID_W-1:0]  pid;
      ts_result_t        res;
      leaving = delay_line[0];
      if (bytes_left != 0) begin
        if (passing) begin
          res.data  = leaving;
          res.first = 1'b0;
          res.last  = (bytes_left == 1);
          expected_bytes.push_back(res);
        end
        bytes_left--;
      end else if (leaving == SYNC_BYTE && incoming == SYNC_BYTE) begin
        pid     = {delay_line[1][PID_W-BYTE_W-1:0], delay_line[2]};
        passing = (pid == wanted_pid);
        if (passing) begin
          res.data  = leaving;
          res.first = 1'b1;
          res.last  = 1'b0;
          expected_bytes.push_back(res);
        end
        bytes_left = PKT_LEN - 1;
      end
      for (int i = 0; i < PKT_LEN - 1; i++) delay_line[i] = delay_line[i + 1];
      delay_line[PKT_LEN - 1] = incoming;
    endfunction

    task report(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
      $display("MISMATCH at %0t ns: %s got %0h, expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_packet_byte(ts_result_t got);
      ts_result_t want;
      if (expected_bytes.size() == 0) begin
        report("packet byte with nothing expected", got.data, '0);
      end else begin
        want = expected_bytes.pop_front();
        if (got.data !== want.data) report("packet_byte", got.data, want.data);
        if (got.first !== want.first) report("is_first", got.first, want.first);
        if (got.last !== want.last) report("is_last", got.last, want.last);
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              stream_valid;
  logic              stream_stall;
  logic [BYTE_W-1:0] stream_byte;
  logic              packet_valid;
  logic              packet_stall;
  logic [BYTE_W-1:0] packet_byte;
  logic              is_first;
  logic              is_last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  passed_packet_predictor passed_pkts;

  // Bytes still to be offered on the stream channel, in order.
  logic [BYTE_W-1:0] stream_plan [$];

  // Idling controls. When a fast flag is set that side never idles; the
  // long hold is a count of cycles during which the receiver stalls.
  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned rx_wait = 0;

  ts_sync_pid_filter #(
    .PACKET_BYTES(PKT_LEN)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .stream_valid(stream_valid),
    .stream_stall(stream_stall),
    .stream_byte (stream_byte),
    .packet_valid(packet_valid),
    .packet_stall(packet_stall),
    .packet_byte (packet_byte),
    .is_first    (is_first),
    .is_last     (is_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver. Outputs are sampled at the rising edge, before the block's own
  // updates of that edge land, and the stall for the next cycle is set with a
  // single nonblocking assignment per edge. After each accepted transaction
  // it draws how many cycles to stall before taking the next one.
  initial begin
    ts_result_t got;
    packet_stall <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && packet_valid && !packet_stall) begin
        got = {packet_byte, is_first, is_last};
        passed_pkts.check_packet_byte(got);
        rx_wait = rx_fast ? 0 : $urandom_range(0, 8);
      end
      if (rx_hold != 0) begin
        packet_stall <= 1'b1;
        rx_hold--;
      end else if (rx_wait != 0) begin
        packet_stall <= 1'b1;
        rx_wait--;
      end else begin
        packet_stall <= 1'b0;
      end
    end
  end

  // Offers one byte after a random gap and returns at the edge that accepts
  // it. Valid stays high on return, so back-to-back bytes need no toggle.
  task automatic send_stream_byte(input logic [BYTE_W-1:0] value);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      stream_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_valid <= 1'b1;
    stream_byte  <= value;
    do @(posedge clk); while (stream_stall);
    passed_pkts.take_stream_byte(value);
  endtask

  task automatic send_planned(input int unsigned count);
    while (count != 0 && stream_plan.size() != 0) begin
      send_stream_byte(stream_plan.pop_front());
      count--;
    end
  endtask

  // Stops offering, waits for every owed packet byte, then lets the output
  // pipeline settle so the block is idle before a register write.
  task automatic wait_until_drained();
    stream_valid <= 1'b0;
    while (passed_pkts.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase APB write; the register takes the value at the access edge.
  task automatic write_register(input logic [APB_AW-1:0] addr,
                                input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    passed_pkts.write_register(addr >> 2, value);
    @(posedge clk);
  endtask

  // Appends one packet-shaped segment to the plan. With fake syncs allowed,
  // about one payload byte in sixteen is a sync byte; otherwise payload
  // never holds one, so a directed packet cannot be shadowed by a false
  // start.
  function automatic void plan_packet(logic [PID_W-1:0] pid, logic [2:0] hdr_flags,
                                      int unsigned len, logic [BYTE_W-1:0] lead,
                                      bit fake_syncs);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      case (i)
        0: begin
          b = lead;
        end
        1: begin
          b = {hdr_flags, pid[PID_W-1:BYTE_W]};
        end
        2: begin
          b = pid[BYTE_W-1:0];
        end
        default: begin
          b = BYTE_W'($urandom);
          if (fake_syncs && $urandom_range(0, 15) == 0) b = SYNC_BYTE;
          if (!fake_syncs && b == SYNC_BYTE) b = '0;
        end
      endcase
      stream_plan.push_back(b);
    end
  endfunction

  initial begin
    logic [PID_W-1:0]  pid_pool [4];
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] lead;
    int unsigned       base;
    int unsigned       kind;
    int unsigned       phase;

    passed_pkts = new();
    rst          <= 1'b1;
    stream_valid <= 1'b0;
    stream_byte  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Start of stream: sync bytes meet an all-zero delay line and must not
    // confirm anything. The first packet carries PID 0, the reset filter.
    stream_plan = {SYNC_BYTE, SYNC_BYTE, 8'h00, 8'hFF, SYNC_BYTE};
    base = stream_plan.size();
    plan_packet(PID_LOWEST, 3'b000, PKT_LEN, SYNC_BYTE, 1'b0);
    stream_plan[base + 3] = 8'h00;
    stream_plan[base + 4] = 8'hFF;
    // The second packet has the highest PID with the flag bits above the PID
    // set, and is dropped. It and the third packet both hold a sync byte at
    // offset 50: a false start inside a confirmed packet, which is ignored.
    base = stream_plan.size();
    plan_packet(PID_HIGHEST, 3'b111, PKT_LEN, SYNC_BYTE, 1'b0);
    stream_plan[base + 50] = SYNC_BYTE;
    // The flag bits of byte 1 are not part of the PID, so this one passes.
    base = stream_plan.size();
    plan_packet(PID_LOWEST, 3'b111, PKT_LEN, SYNC_BYTE, 1'b0);
    stream_plan[base + 50] = SYNC_BYTE;
    plan_packet(PID_HIGHEST, 3'b000, PKT_LEN, SYNC_BYTE, 1'b0);

    // Stop halfway into the fourth packet, while the third is still leaving
    // the block. Its pass decision is latched, so the filter change below
    // must not cut it short. The write with all bits set keeps only the low
    // thirteen; the write to the empty index must have no effect.
    send_planned(5 + 3 * PKT_LEN + PKT_LEN / 2);
    wait_until_drained();
    write_register(ADDR_WANTED_PID, '1);
    write_register(ADDR_NO_REGISTER, '0);
    send_planned(stream_plan.size());

    // The fifth packet confirms the fourth, which now passes. The receiver
    // holds off for a long stretch while the sender offers every cycle, so
    // the output and skid registers fill and the input must stall.
    plan_packet(PID_HIGHEST, 3'b010, PKT_LEN, SYNC_BYTE, 1'b0);
    tx_fast = 1'b1;
    rx_hold = LONG_HOLD;
    send_planned(stream_plan.size());
    tx_fast = 1'b0;

    // A short run of junk after a packet: the junk's lead sync byte confirms
    // the fifth packet, then the hunt must find the next real start.
    stream_plan = {SYNC_BYTE, 8'h12, SYNC_BYTE};
    plan_packet(PID_HIGHEST, 3'b101, PKT_LEN, SYNC_BYTE, 1'b0);
    plan_packet(PID_HIGHEST, 3'b000, PKT_LEN, SYNC_BYTE, 1'b0);
    send_planned(stream_plan.size());

    // Random stream. Mostly well-formed packets drawn from a small PID pool
    // so that the filter often matches, mixed with junk runs, truncated
    // packets and packets with a broken sync byte.
    pid_pool[0] = PID_LOWEST;
    pid_pool[1] = PID_HIGHEST;
    pid_pool[2] = PID_W'($urandom);
    pid_pool[3] = PID_W'($urandom);
    while (stream_plan.size() < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      pid  = ($urandom_range(0, 9) == 0) ? PID_W'($urandom) : pid_pool[$urandom_range(0, 3)];
      if (kind < 7) begin
        plan_packet(pid, 3'($urandom), PKT_LEN, SYNC_BYTE, 1'b1);
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 12))
          stream_plan.push_back(($urandom_range(0, 3) == 0) ? SYNC_BYTE : BYTE_W'($urandom));
      end else if (kind == 8) begin
        plan_packet(pid, 3'($urandom), $urandom_range(3, PKT_LEN - 1), SYNC_BYTE, 1'b1);
      end else begin
        lead = BYTE_W'($urandom);
        if (lead == SYNC_BYTE) lead = lead ^ 8'h01;
        plan_packet(pid, 3'($urandom), PKT_LEN, lead, 1'b1);
      end
    end

    // Phases of random length; each starts idle with a new filter value that
    // carries random bits above the PID, and new idling modes. Phases end at
    // arbitrary bytes, often in the middle of a packet.
    phase = 0;
    while (stream_plan.size() != 0) begin
      wait_until_drained();
      pid = (phase < 2) ? pid_pool[phase] : pid_pool[$urandom_range(0, 3)];
      write_register(ADDR_WANTED_PID, {(APB_DW - PID_W)'($urandom), pid});
      if ($urandom_range(0, 3) == 0) write_register(ADDR_NO_REGISTER, $urandom);
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      send_planned($urandom_range(250, 600));
      phase++;
    end

    wait_until_drained();
    repeat (20) @(posedge clk);
    if (passed_pkts.mismatches == 0 && passed_pkts.expected_bytes.size() == 0) begin
      $display("ts_sync_pid_filter test passed");
    end else begin
      $display("ts_sync_pid_filter test failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("ts_sync_pid_filter test failed");
    $finish;
  end

endmodule
